// ===== rtl/core/gdsamp_pkg.sv =====
// ----------------------------------------------------------------------------
// gdsamp_pkg
// Shared constants, tap table and types for the binomial downsampler.
// ----------------------------------------------------------------------------
package gdsamp_pkg;

  // filter geometry
  localparam int NTAPS     = 12;
  localparam int NLINES    = 11;
  localparam int TAP_BITS  = 9;
  localparam int FRAC_BITS = 11;
  localparam int SLOT_BITS = 4;

  // counters and result fields
  localparam int ROW_BITS     = 11;
  localparam int CFG_BITS     = 12;
  localparam int COL_OUT_BITS = 10;
  localparam int ROW_OUT_BITS = 10;

  // size limits
  localparam logic [CFG_BITS-1:0] MIN_SIZE   = 12'd16;
  localparam logic [CFG_BITS-1:0] MAX_HEIGHT = 12'd2048;

  // apb register map
  localparam int ADDR_BITS   = 3;
  localparam int REG_IDX_BIT = 2;
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // binomial taps, sum 2048
  localparam logic [TAP_BITS-1:0] TAPS [NTAPS] = '{
    9'd1, 9'd11, 9'd55, 9'd165, 9'd330, 9'd462,
    9'd462, 9'd330, 9'd165, 9'd55, 9'd11, 9'd1
  };

  // tap that line memory 'line' gets when the current row sits in slot 'rmod'
  function automatic logic [TAP_BITS-1:0] line_tap(input logic [SLOT_BITS-1:0] line,
                                                   input logic [SLOT_BITS-1:0] rmod);
    logic [SLOT_BITS:0] k;
    k = {1'b0, line} + (SLOT_BITS+1)'(NLINES) - {1'b0, rmod};
    if (k >= (SLOT_BITS+1)'(NLINES)) begin
      k = k - (SLOT_BITS+1)'(NLINES);
    end
    return TAPS[k[SLOT_BITS-1:0]];
  endfunction

  // controls shared by every line cell
  typedef struct packed {
    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_slot;
    logic                 rd_en;
    logic                 prod_en;
    logic [SLOT_BITS-1:0] rmod;
  } line_ctrl_t;

endpackage

// ===== rtl/core/gdsamp_pix_if.sv =====
// ----------------------------------------------------------------------------
// gdsamp_pix_if
// Pixel stream channel: one sample and a frame start mark per transaction.
// ----------------------------------------------------------------------------
interface gdsamp_pix_if #(parameter int SAMPLE_BITS = 16);

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] pixel;
  logic                   frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);

endinterface

// ===== rtl/core/gdsamp_res_if.sv =====
// ----------------------------------------------------------------------------
// gdsamp_res_if
// Result channel: one filtered sample with its position per transaction.
// ----------------------------------------------------------------------------
interface gdsamp_res_if #(parameter int SAMPLE_BITS = 16);

  logic                                   valid;
  logic                                   ready;
  logic [SAMPLE_BITS-1:0]                 value;
  logic [gdsamp_pkg::COL_OUT_BITS-1:0]    out_col;
  logic [gdsamp_pkg::ROW_OUT_BITS-1:0]    out_row;
  logic                                   frame_end;

  modport source (output valid, value, out_col, out_row, frame_end, input ready);
  modport sink   (input valid, value, out_col, out_row, frame_end, output ready);

endinterface

// ===== rtl/core/gaussian_downsample_by_two_top.sv =====
// ----------------------------------------------------------------------------
// gaussian_downsample_by_two_top
// Separable 12-tap binomial filter with downsampling by two for a raster
// pixel stream; emits interior output samples only.
// ----------------------------------------------------------------------------
//  channel | direction | transaction carries
//  pix     | in        | pixel, frame_start
//  res     | out       | value, out_col, out_row, frame_end
//  apb     | in/out    | image_width (0x0), image_height (0x4)
//
// One pixel is accepted every clock while stage 1 is not blocked; the result
// at (x, y) leaves once pixel (2x+6, 2y+6) has passed the tap cell chain, the
// registered line memory read, the product stage and a two-level adder tree.
// Reset clears counters and pipeline valids; line memories hold no reset and
// need no clearing pass. A stalled result fills bubbles behind it, so pixels
// that produce no result keep flowing until a result-bearing stage is blocked.
module gaussian_downsample_by_two_top #(
  parameter int MAX_WIDTH   = 2048,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  gdsamp_pix_if.sink                       pix,
  gdsamp_res_if.source                     res,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gdsamp_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import gdsamp_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = CW + 1;
  localparam int DEPTH  = MAX_WIDTH / 2;
  localparam int XW     = $clog2(DEPTH);
  localparam int ACC_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int PROD_W = SAMPLE_BITS + TAP_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  // frame size
  logic [WW-1:0]       w_eff;
  logic [CFG_BITS-1:0] h_eff;

  // position counters
  logic [CW-1:0]        in_col;
  logic [ROW_BITS-1:0]  in_row;
  logic [SLOT_BITS-1:0] rmod;

  // stage 0 decode
  logic                    accept;
  logic [CW-1:0]           c0;
  logic [ROW_BITS-1:0]     r0;
  logic [SLOT_BITS-1:0]    m0;
  logic [WW-1:0]           c_ext;
  logic [CFG_BITS-1:0]     r_ext;
  logic [CW-1:0]           c_m6;
  logic [ROW_BITS-1:0]     r_m6;
  logic                    h_en0;
  logic                    v_en0;
  logic                    fe0;

  // horizontal chain
  logic [ACC_W-1:0] hpart [NTAPS+1];

  // stage 1
  logic                    v1, ven1, fe1;
  logic [XW-1:0]           x1;
  logic [ROW_OUT_BITS-1:0] y1;
  logic [SLOT_BITS-1:0]    m1;
  logic [SAMPLE_BITS-1:0]  hval1;
  logic                    leave1, load2;

  // stages 2 to 5 and output
  logic                    v2, v3, v4, v5, ov;
  logic                    fe2, fe3, fe4, fe5;
  logic [XW-1:0]           x2, x3, x4, x5;
  logic [ROW_OUT_BITS-1:0] y2, y3, y4, y5;
  logic [SLOT_BITS-1:0]    m2;
  logic [SAMPLE_BITS-1:0]  hval2, hval3;
  logic [ACC_W-1:0]        psum [4];
  logic [ACC_W-1:0]        total;
  logic                    rdy2, rdy3, rdy4, rdy5, rdy6;

  // line cells
  line_ctrl_t        lctrl;
  logic [PROD_W-1:0] prod [NLINES];

  // ready chain, bubbles collapse
  assign rdy6   = !ov || res.ready;
  assign rdy5   = !v5 || rdy6;
  assign rdy4   = !v4 || rdy5;
  assign rdy3   = !v3 || rdy4;
  assign rdy2   = !v2 || rdy3;
  assign leave1 = v1 && (!ven1 || rdy2);
  assign load2  = v1 && ven1 && rdy2;

  assign pix.ready = !v1 || leave1;
  assign accept    = pix.valid && pix.ready;

  gdsamp_csr #(.MAX_WIDTH(MAX_WIDTH)) u_csr (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .w_eff   (w_eff),
    .h_eff   (h_eff)
  );

  // position decode for the incoming pixel
  always_comb begin
    c0    = pix.frame_start ? '0 : in_col;
    r0    = pix.frame_start ? '0 : in_row;
    m0    = pix.frame_start ? '0 : rmod;
    c_ext = WW'(c0);
    r_ext = CFG_BITS'(r0);
    c_m6  = c0 - CW'(6);
    r_m6  = r0 - ROW_BITS'(6);
    h_en0 = (c_ext >= WW'(12)) && (c_ext + WW'(2) <= w_eff) && !c0[0];
    v_en0 = h_en0 && (r_ext >= CFG_BITS'(12)) && (r_ext + CFG_BITS'(2) <= h_eff) && !r0[0];
    fe0   = (c_ext + WW'(2) == w_eff) && (r_ext + CFG_BITS'(2) == h_eff);
  end

  // column, row and row slot counters
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col <= '0;
      in_row <= '0;
      rmod   <= '0;
    end else if (accept) begin
      if (c_ext + WW'(1) >= w_eff) begin
        in_col <= '0;
        if (r_ext + CFG_BITS'(1) >= h_eff) begin
          in_row <= '0;
          rmod   <= '0;
        end else begin
          in_row <= r0 + ROW_BITS'(1);
          rmod   <= (m0 == SLOT_BITS'(NLINES - 1)) ? '0 : m0 + SLOT_BITS'(1);
        end
      end else begin
        in_col <= c0 + CW'(1);
        in_row <= r0;
        rmod   <= m0;
      end
    end
  end

  // horizontal filter: chain of tap cells, hpart[0] holds the full sum
  assign hpart[NTAPS] = '0;
  for (genvar j = 0; j < NTAPS; j++) begin : g_tap
    gdsamp_tap_cell #(
      .TAP_IDX     (j),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_W       (ACC_W)
    ) u_tap (
      .clk      (clk),
      .en       (accept),
      .sample   (pix.pixel),
      .part_in  (hpart[j+1]),
      .part_out (hpart[j])
    );
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= h_en0;
    end else if (leave1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ven1 <= v_en0;
      x1   <= XW'(c_m6 >> 1);
      y1   <= ROW_OUT_BITS'(r_m6 >> 1);
      fe1  <= fe0;
      m1   <= m0;
    end
  end

  assign hval1 = SAMPLE_BITS'((hpart[0] + HALF) >> FRAC_BITS);

  // line cell controls
  always_comb begin
    lctrl.wr_en   = leave1;
    lctrl.wr_slot = m1;
    lctrl.rd_en   = load2;
    lctrl.prod_en = rdy3;
    lctrl.rmod    = m2;
  end

  for (genvar m = 0; m < NLINES; m++) begin : g_line
    gdsamp_line_cell #(
      .LINE        (m),
      .DEPTH       (DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_line (
      .clk   (clk),
      .ctrl  (lctrl),
      .addr  (x1),
      .wdata (hval1),
      .prod  (prod[m])
    );
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (rdy2) v2 <= load2;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) ov <= v5;
    end
  end

  // stage 2: line data captured in the cells
  always_ff @(posedge clk) begin
    if (load2) begin
      hval2 <= hval1;
      x2    <= x1;
      y2    <= y1;
      fe2   <= fe1;
      m2    <= m1;
    end
  end

  // stage 3: products captured in the cells
  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      hval3 <= hval2;
      x3    <= x2;
      y3    <= y2;
      fe3   <= fe2;
    end
  end

  // stage 4: partial sums of three
  always_ff @(posedge clk) begin
    if (v3 && rdy4) begin
      psum[0] <= ACC_W'(prod[0]) + ACC_W'(prod[1]) + ACC_W'(prod[2]);
      psum[1] <= ACC_W'(prod[3]) + ACC_W'(prod[4]) + ACC_W'(prod[5]);
      psum[2] <= ACC_W'(prod[6]) + ACC_W'(prod[7]) + ACC_W'(prod[8]);
      psum[3] <= ACC_W'(prod[9]) + ACC_W'(prod[10]) + ACC_W'(hval3);
      x4      <= x3;
      y4      <= y3;
      fe4     <= fe3;
    end
  end

  // stage 5: total
  always_ff @(posedge clk) begin
    if (v4 && rdy5) begin
      total <= psum[0] + psum[1] + psum[2] + psum[3];
      x5    <= x4;
      y5    <= y4;
      fe5   <= fe4;
    end
  end

  // output register with rounding
  always_ff @(posedge clk) begin
    if (v5 && rdy6) begin
      res.value     <= SAMPLE_BITS'((total + HALF) >> FRAC_BITS);
      res.out_col   <= COL_OUT_BITS'(x5);
      res.out_row   <= y5;
      res.frame_end <= fe5;
    end
  end

  assign res.valid = ov;

`ifndef NO_ASSERTIONS
  // a blocked stage 1 item must hold off new pixels
  a_stage1_block: assert property (@(posedge clk) disable iff (rst)
    v1 && !leave1 |-> !pix.ready)
    else $error("pixel accepted while stage 1 is blocked");

  // row slot restarts with the row counter
  a_slot_row0: assert property (@(posedge clk) disable iff (rst)
    (in_row == '0) |-> (rmod == '0))
    else $error("row slot out of step with row counter");

  // a blocked total keeps its value
  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    v5 && !rdy6 |=> v5 && $stable(total))
    else $error("stalled sum stage lost its item");
`endif

endmodule

// ===== rtl/core/gdsamp_csr.sv =====
// ----------------------------------------------------------------------------
// gdsamp_csr
// APB size registers and the effective (even, clamped) frame size.
// ----------------------------------------------------------------------------
module gdsamp_csr #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gdsamp_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic [$clog2(MAX_WIDTH):0]       w_eff,
  output logic [gdsamp_pkg::CFG_BITS-1:0]  h_eff
);
  import gdsamp_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH) + 1;

  logic [CFG_BITS-1:0] image_width;
  logic [CFG_BITS-1:0] image_height;
  logic                wr_hit;
  logic [CFG_BITS-1:0] w_even;
  logic [CFG_BITS-1:0] h_even;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 12'd640;
      image_height <= 12'd480;
    end else if (wr_hit) begin
      unique case (paddr[REG_IDX_BIT])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_BITS-1:0];
        default:          image_width  <= image_width;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[REG_IDX_BIT])
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

  // drop the low bit, then clamp to the supported range
  always_comb begin
    w_even = {image_width[CFG_BITS-1:1], 1'b0};
    h_even = {image_height[CFG_BITS-1:1], 1'b0};
    if (w_even < MIN_SIZE) begin
      w_eff = WW'(MIN_SIZE);
    end else if (32'(w_even) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_even);
    end
    if (h_even < MIN_SIZE) begin
      h_eff = MIN_SIZE;
    end else if (h_even > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = h_even;
    end
  end

`ifndef NO_ASSERTIONS
  // a width write lands in the register
  a_width_write: assert property (@(posedge clk) disable iff (rst)
    wr_hit && (paddr[REG_IDX_BIT] == REG_IMAGE_WIDTH)
      |=> image_width == $past(pwdata[CFG_BITS-1:0]))
    else $error("width register did not take the written value");

  // effective sizes are even and at least the minimum
  a_eff_even: assert property (@(posedge clk) disable iff (rst)
    !w_eff[0] && !h_eff[0] && (h_eff >= MIN_SIZE) && (32'(w_eff) >= 32'(MIN_SIZE)))
    else $error("effective frame size out of range");
`endif

endmodule

// ===== rtl/core/gdsamp_tap_cell.sv =====
// ----------------------------------------------------------------------------
// gdsamp_tap_cell
// One cell of the horizontal filter chain: adds its weighted sample to the
// partial sum handed over by its neighbor.
// ----------------------------------------------------------------------------
module gdsamp_tap_cell #(
  parameter int TAP_IDX     = 0,
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_W       = 27
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [ACC_W-1:0]       part_in,
  output logic [ACC_W-1:0]       part_out
);
  import gdsamp_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + TAP_BITS;

  logic [PROD_W-1:0] prod;

  // constant-coefficient product
  assign prod = PROD_W'(sample) * PROD_W'(TAPS[TAP_IDX]);

  // partial sum moves one cell along on every accepted sample
  always_ff @(posedge clk) begin
    if (en) begin
      part_out <= part_in + ACC_W'(prod);
    end
  end

endmodule

// ===== rtl/core/gdsamp_line_cell.sv =====
// ----------------------------------------------------------------------------
// gdsamp_line_cell
// One line of the row store: a half-width line memory and the weighted
// product of the entry read for the current column.
// ----------------------------------------------------------------------------
module gdsamp_line_cell #(
  parameter int LINE        = 0,
  parameter int DEPTH       = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  gdsamp_pkg::line_ctrl_t              ctrl,
  input  logic [$clog2(DEPTH)-1:0]            addr,
  input  logic [SAMPLE_BITS-1:0]              wdata,
  output logic [SAMPLE_BITS+gdsamp_pkg::TAP_BITS-1:0] prod
);
  import gdsamp_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + TAP_BITS;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [TAP_BITS-1:0]    coef;

  // tap for this line depends on where the current row sits in the rotation
  assign coef = line_tap(SLOT_BITS'(LINE), ctrl.rmod);

  // line memory: write current row's slot, read before write at same address
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (ctrl.wr_slot == SLOT_BITS'(LINE))) begin
      mem[addr] <= wdata;
    end
    if (ctrl.rd_en) begin
      rd_q <= mem[addr];
    end
  end

  // weighted product
  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod <= PROD_W'(rd_q) * PROD_W'(coef);
    end
  end

endmodule
